// ----- hw/rtl/chacha_pkg.sv -----
// ChaCha20 stream cipher unit: shared types, register indexes and round helpers.
// Depends on nothing; imported by chacha20_stream_cipher_unit.
`default_nettype none

package chacha_pkg;

  localparam int unsigned DOUBLE_ROUNDS = 10;
  localparam int unsigned DR_W          = $clog2(DOUBLE_ROUNDS);
  localparam int unsigned WORDS         = 16;

  typedef logic [31:0]           word_t;
  typedef word_t [WORDS-1:0]     state_t;
  typedef logic [2:0]            cfg_idx_t;
  typedef logic [5:0]            byte_pos_t;

  localparam cfg_idx_t REG_KEY_PART_0      = 3'd0;
  localparam cfg_idx_t REG_KEY_PART_1      = 3'd1;
  localparam cfg_idx_t REG_KEY_PART_2      = 3'd2;
  localparam cfg_idx_t REG_KEY_PART_3      = 3'd3;
  localparam cfg_idx_t REG_NONCE_LOW       = 3'd4;
  localparam cfg_idx_t REG_NONCE_HIGH      = 3'd5;
  localparam cfg_idx_t REG_INITIAL_COUNTER = 3'd6;

  // "expand 32-byte k"
  localparam word_t SIGMA_0 = 32'h6170_7865;
  localparam word_t SIGMA_1 = 32'h3320_646e;
  localparam word_t SIGMA_2 = 32'h7962_2d32;
  localparam word_t SIGMA_3 = 32'h6b20_6574;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FEED,
    ST_EMIT
  } fsm_t;

  typedef enum logic [1:0] {
    PERM_PLAIN,
    PERM_DIAG_IN,
    PERM_DIAG_OUT
  } perm_t;

  // rotate amount per quarter-round sub-step: 16, 12, 8, 7
  function automatic word_t mix_rotate(input word_t v, input logic [1:0] sub);
    word_t r;
    case (sub)
      2'd0:    r = {v[15:0], v[31:16]};
      2'd1:    r = {v[19:0], v[31:20]};
      2'd2:    r = {v[23:0], v[31:24]};
      default: r = {v[24:0], v[31:25]};
    endcase
    return r;
  endfunction

  // rotate each row of the 4x4 state left; column 0 then holds the next quarter-round
  function automatic state_t row_shift(input state_t s, input perm_t mode);
    state_t     r;
    logic [1:0] amt;
    logic [1:0] col;
    r = s;
    for (int row = 0; row < 4; row++) begin
      unique case (mode)
        PERM_PLAIN:    amt = 2'd1;
        PERM_DIAG_IN:  amt = 2'(row + 1);
        PERM_DIAG_OUT: amt = 2'(1 - row);
        default:       amt = 2'd1;
      endcase
      for (int c = 0; c < 4; c++) begin
        col = 2'(c) + amt;
        r[4*row + c] = s[4*row + int'(col)];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/chacha20_stream_cipher_unit.sv -----
// ChaCha20 stream cipher unit (IETF: 256-bit key, 96-bit nonce, 32-bit counter).
// Depends on chacha_pkg.
//
// Usage: configuration is written through cfg_write_en / cfg_index / cfg_data while
// the unit is idle. Input words (data_byte, last_byte) arrive on in_valid / in_stall,
// results (result_byte, result_last) leave on out_valid / out_stall. A word is taken
// at a clock edge where valid is high and stall is low.
// The first word of a message and every 64th word after it start a new keystream
// block: the state is loaded at the edge that takes the word, then one shared
// quarter-round unit (one 32-bit add, xor and rotate per cycle) runs 4 sub-steps per
// quarter-round, 8 quarter-rounds per double round, then 16 feed-forward adds
// through the same adder, and an emit state registers the result. in_stall stays
// high from the take until the emit state is over. Other words give their result
// in the cycle after they are taken, one per cycle while the output is not stalled.
// A stalled result sits in the output register; outside a block, in_stall is raised
// only when that register is full and stalled. last_byte closes the message; the
// next word reloads the counter from initial_counter. Reset (rst, synchronous)
// clears the control and configuration registers to zero and leaves no message open.
`default_nettype none

module chacha20_stream_cipher_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write_en,
  input  wire chacha_pkg::cfg_idx_t cfg_index,
  input  wire logic [63:0]         cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [7:0]          data_byte,
  input  wire logic                last_byte,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               result_byte,
  output logic                     result_last
);
  import chacha_pkg::*;

  logic [63:0] key_part_0, key_part_1, key_part_2, key_part_3, nonce_low;
  word_t       nonce_high, initial_counter;

  fsm_t        state, state_next;
  state_t      x;
  byte_pos_t   byte_position;
  word_t       block_counter;
  logic        in_message;
  logic [7:0]  data_hold;
  logic        last_hold;

  logic [1:0]      sub_cnt;
  logic [2:0]      qr_cnt;
  logic [DR_W-1:0] dr_cnt;
  logic [3:0]      word_idx;

  logic      accept, need_block, round_last, feed_last, odd;
  byte_pos_t pos_use;
  word_t     ctr_use, op_p, op_q, op_r, sum, mix;
  state_t    init_state, upd, round_next;
  perm_t     perm_mode;
  logic [7:0] ks_byte;

  assign in_stall   = (state != ST_IDLE) || (out_valid && out_stall);
  assign accept     = in_valid && !in_stall;
  assign pos_use    = in_message ? byte_position : '0;
  assign need_block = (pos_use == '0);
  assign ctr_use    = in_message ? block_counter : initial_counter;
  assign round_last = (sub_cnt == 2'd3) && (qr_cnt == 3'd7) &&
                      (dr_cnt == DR_W'(DOUBLE_ROUNDS - 1));
  assign feed_last  = (word_idx == 4'd15);
  assign odd        = sub_cnt[0];

  always_comb begin
    init_state[0]  = SIGMA_0;
    init_state[1]  = SIGMA_1;
    init_state[2]  = SIGMA_2;
    init_state[3]  = SIGMA_3;
    init_state[4]  = key_part_0[31:0];
    init_state[5]  = key_part_0[63:32];
    init_state[6]  = key_part_1[31:0];
    init_state[7]  = key_part_1[63:32];
    init_state[8]  = key_part_2[31:0];
    init_state[9]  = key_part_2[63:32];
    init_state[10] = key_part_3[31:0];
    init_state[11] = key_part_3[63:32];
    init_state[12] = (state == ST_IDLE) ? ctr_use : block_counter;
    init_state[13] = nonce_low[31:0];
    init_state[14] = nonce_low[63:32];
    init_state[15] = nonce_high;
  end

  // shared unit: one add, one xor-rotate
  always_comb begin
    if (state == ST_FEED) begin
      op_p = x[0];
      op_q = init_state[word_idx];
    end else if (odd) begin
      op_p = x[8];
      op_q = x[12];
    end else begin
      op_p = x[0];
      op_q = x[4];
    end
    op_r = odd ? x[4] : x[12];
    sum  = op_p + op_q;
    mix  = mix_rotate(op_r ^ sum, sub_cnt);

    upd = x;
    if (odd) begin
      upd[8] = sum;
      upd[4] = mix;
    end else begin
      upd[0]  = sum;
      upd[12] = mix;
    end

    case (qr_cnt)
      3'd3:    perm_mode = PERM_DIAG_IN;
      3'd7:    perm_mode = PERM_DIAG_OUT;
      default: perm_mode = PERM_PLAIN;
    endcase
    round_next = (sub_cnt == 2'd3) ? row_shift(upd, perm_mode) : upd;
  end

  assign ks_byte = x[pos_use[5:2]][{pos_use[1:0], 3'b000} +: 8];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept && need_block) state_next = ST_ROUND;
      ST_ROUND: if (round_last) state_next = ST_FEED;
      ST_FEED:  if (feed_last) state_next = ST_EMIT;
      ST_EMIT:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      out_valid       <= 1'b0;
      in_message      <= 1'b0;
      byte_position   <= '0;
      block_counter   <= '0;
      sub_cnt         <= '0;
      qr_cnt          <= '0;
      dr_cnt          <= '0;
      word_idx        <= '0;
      key_part_0      <= '0;
      key_part_1      <= '0;
      key_part_2      <= '0;
      key_part_3      <= '0;
      nonce_low       <= '0;
      nonce_high      <= '0;
      initial_counter <= '0;
    end else begin
      state <= state_next;

      if (cfg_write_en) begin
        case (cfg_index)
          REG_KEY_PART_0:      key_part_0      <= cfg_data;
          REG_KEY_PART_1:      key_part_1      <= cfg_data;
          REG_KEY_PART_2:      key_part_2      <= cfg_data;
          REG_KEY_PART_3:      key_part_3      <= cfg_data;
          REG_NONCE_LOW:       nonce_low       <= cfg_data;
          REG_NONCE_HIGH:      nonce_high      <= cfg_data[31:0];
          REG_INITIAL_COUNTER: initial_counter <= cfg_data[31:0];
          default: ;
        endcase
      end

      if (accept) begin
        in_message    <= !last_byte;
        byte_position <= last_byte ? '0 : pos_use + 6'd1;
        if (need_block) block_counter <= ctr_use;
      end

      if (state == ST_ROUND) begin
        sub_cnt <= sub_cnt + 2'd1;
        if (sub_cnt == 2'd3) qr_cnt <= qr_cnt + 3'd1;
        if (round_last) begin
          dr_cnt <= '0;
        end else if (sub_cnt == 2'd3 && qr_cnt == 3'd7) begin
          dr_cnt <= dr_cnt + DR_W'(1);
        end
      end

      if (state == ST_FEED) word_idx <= word_idx + 4'd1;

      if (state == ST_EMIT) block_counter <= block_counter + 32'd1;

      if ((accept && !need_block) || state == ST_EMIT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_hold <= data_byte;
      last_hold <= last_byte;
    end

    if (state == ST_IDLE && accept && need_block) begin
      x <= init_state;
    end else if (state == ST_ROUND) begin
      x <= round_next;
    end else if (state == ST_FEED) begin
      x <= {sum, x[WORDS-1:1]};
    end

    if (accept && !need_block) begin
      result_byte <= data_byte ^ ks_byte;
      result_last <= last_byte;
    end else if (state == ST_EMIT) begin
      result_byte <= data_hold ^ x[0][7:0];
      result_last <= last_hold;
    end
  end

endmodule

`default_nettype wire

// ----- dv/chacha20_stream_cipher_unit_tb.sv -----
// Self-checking testbench for chacha20_stream_cipher_unit: drives messages of byte words
// under several register settings and idle patterns, and predicts each output word.
// Depends on chacha_pkg and chacha20_stream_cipher_unit.

module chacha20_stream_cipher_unit_tb;
  import chacha_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cipher_word_t;

  class keystream_scoreboard;
    logic [63:0]  key_q[4];
    logic [63:0]  nonce_lo;
    logic [31:0]  nonce_hi;
    logic [31:0]  ctr_init;
    word_t        ks[16];
    word_t        mix[16];
    logic [5:0]   pos;
    logic [31:0]  ctr;
    logic         msg_open;
    cipher_word_t expected_q[$];
    int           errors;

    function new();
      foreach (key_q[i]) key_q[i] = '0;
      nonce_lo = '0;
      nonce_hi = '0;
      ctr_init = '0;
      pos      = '0;
      ctr      = '0;
      msg_open = 1'b0;
      errors   = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [63:0] v);
      case (idx)
        REG_KEY_PART_0:      key_q[0] = v;
        REG_KEY_PART_1:      key_q[1] = v;
        REG_KEY_PART_2:      key_q[2] = v;
        REG_KEY_PART_3:      key_q[3] = v;
        REG_NONCE_LOW:       nonce_lo = v;
        REG_NONCE_HIGH:      nonce_hi = v[31:0];
        REG_INITIAL_COUNTER: ctr_init = v[31:0];
        default: ;
      endcase
    endfunction

    function word_t rotl(word_t v, int n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function void qr(int a, int b, int c, int d);
      mix[a] = mix[a] + mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 16);
      mix[c] = mix[c] + mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 12);
      mix[a] = mix[a] + mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 8);
      mix[c] = mix[c] + mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 7);
    endfunction

    function void build_block();
      word_t init_w[16];
      init_w[0] = SIGMA_0;
      init_w[1] = SIGMA_1;
      init_w[2] = SIGMA_2;
      init_w[3] = SIGMA_3;
      foreach (key_q[i]) begin
        init_w[4 + 2*i] = key_q[i][31:0];
        init_w[5 + 2*i] = key_q[i][63:32];
      end
      init_w[12] = ctr;
      init_w[13] = nonce_lo[31:0];
      init_w[14] = nonce_lo[63:32];
      init_w[15] = nonce_hi;
      mix = init_w;
      for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
        qr(0, 4, 8, 12);
        qr(1, 5, 9, 13);
        qr(2, 6, 10, 14);
        qr(3, 7, 11, 15);
        qr(0, 5, 10, 15);
        qr(1, 6, 11, 12);
        qr(2, 7, 8, 13);
        qr(3, 4, 9, 14);
      end
      foreach (ks[i]) ks[i] = mix[i] + init_w[i];
    endfunction

    function void note_input(logic [7:0] d, logic l);
      word_t w;
      if (!msg_open) begin
        ctr      = ctr_init;
        pos      = '0;
        msg_open = 1'b1;
      end
      if (pos == 0) begin
        build_block();
        ctr = ctr + 32'd1;
      end
      w = ks[pos[5:2]];
      expected_q.push_back('{data: d ^ w[8*pos[1:0] +: 8], last: l});
      pos = pos + 6'd1;
      if (l) begin
        msg_open = 1'b0;
        pos      = '0;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string what);
      errors++;
      $display("MISMATCH @%0t: %s", $time, what);
    endtask

    task check_result(logic [7:0] d, logic l);
      cipher_word_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected word result_byte=%02h result_last=%0b", d, l));
        return;
      end
      want = expected_q.pop_front();
      if (d !== want.data)
        report($sformatf("result_byte %02h, predicted %02h", d, want.data));
      if (l !== want.last)
        report($sformatf("result_last %0b, predicted %0b", l, want.last));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_write_en;
  cfg_idx_t    cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [7:0]  result_byte;
  logic        result_last;

  keystream_scoreboard sb = new();

  int idle_pct  = 0;
  int stall_pct = 0;
  bit hold_req  = 1'b0;
  int hold_left = 0;

  chacha20_stream_cipher_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_byte  (result_byte),
    .result_last  (result_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("chacha20_stream_cipher_unit verification failed");
    $finish;
  end

  // long hold-off requested by the main sequence, else random stalls
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 300;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(result_byte, result_last);
  end

  task automatic send_word(input logic [7:0] d, input logic l);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid  <= 1'b0;
      data_byte <= 8'($urandom);
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= d;
    last_byte <= l;
    do @(posedge clk); while (in_stall);
    sb.note_input(d, l);
  endtask

  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] v);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= v;
    sb.set_reg(idx, v);
  endtask

  task automatic load_regs(input logic [63:0] k0, input logic [63:0] k1,
                           input logic [63:0] k2, input logic [63:0] k3,
                           input logic [63:0] nlo, input logic [63:0] nhi,
                           input logic [63:0] ctr0);
    write_reg(REG_KEY_PART_0, k0);
    write_reg(REG_KEY_PART_1, k1);
    write_reg(REG_KEY_PART_2, k2);
    write_reg(REG_KEY_PART_3, k3);
    write_reg(REG_NONCE_LOW, nlo);
    write_reg(REG_NONCE_HIGH, nhi);
    write_reg(REG_INITIAL_COUNTER, ctr0);
    @(negedge clk) cfg_write_en <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // messages of random length; the final one may be left open across the next setting
  task automatic send_messages(input int n_words, input bit leave_open);
    int sent;
    int len;
    int fill;
    int r;
    logic [7:0] d;
    sent = 0;
    while (sent < n_words) begin
      r = $urandom_range(99);
      if (r < 15)      len = 1;
      else if (r < 70) len = $urandom_range(64, 2);
      else if (r < 90) len = $urandom_range(130, 65);
      else             len = $urandom_range(200, 131);
      fill = $urandom_range(9);
      for (int i = 0; i < len && sent < n_words; i++) begin
        case (fill)
          0:       d = 8'h00;
          1:       d = 8'hff;
          default: d = 8'($urandom);
        endcase
        sent++;
        send_word(d, (i == len - 1) || (sent == n_words && !leave_open));
      end
    end
  endtask

  initial begin
    string txt;
    int    cfg_kind;
    logic [31:0] ctr0;
    txt          = "Ladies and Gentlemen";
    rst          = 1'b1;
    cfg_write_en = 1'b0;
    cfg_index    = REG_KEY_PART_0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    data_byte    = '0;
    last_byte    = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // reset setting, short messages and a one-word message
    send_word(8'h00, 1'b0);
    send_word(8'hff, 1'b1);
    send_word(8'h5a, 1'b1);
    drain();

    // RFC test key and nonce, counter 1
    load_regs(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
              64'h1716151413121110, 64'h1f1e1d1c1b1a1918,
              64'h4a00000000000000, 64'h0, 64'h1);
    for (int i = 0; i < 12; i++)
      send_word(txt[i], i == 11);
    drain();

    load_regs('1, '1, '1, '1, '1, '1, '1);
    send_word(8'hff, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h01, 1'b1);
    drain();

    for (int phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 78; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 78; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      if (phase == 0 || phase == 8)
        hold_req = 1'b1;
      cfg_kind = (phase + 1) % 3;
      if (cfg_kind == 0) begin
        load_regs('0, '0, '0, '0, '0, {$urandom, 32'h0}, {$urandom, 32'h0});
      end else if (cfg_kind == 1) begin
        load_regs('1, '1, '1, '1, '1, '1, {$urandom, 32'hffff_ffff});
      end else begin
        ctr0 = ($urandom_range(1) != 0) ? 32'hffff_fffe + $urandom_range(1) : $urandom;
        load_regs(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
                  {$urandom, ctr0});
      end
      send_messages(137, $urandom_range(2) == 0);
      drain();
    end

    idle_pct  = 0;
    stall_pct = 0;
    repeat (400) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d predicted words never arrived", sb.pending()));
    if (sb.errors == 0)
      $display("chacha20_stream_cipher_unit verification clean");
    else
      $display("chacha20_stream_cipher_unit verification failed");
    $finish;
  end

endmodule
